>>> hdl/fcba_pkg.sv
// fcba_pkg: shared constants, codes, beat types and the controller/datapath
// command and status structs for the fat chain block allocator.
// No dependencies.
package fcba_pkg;

  localparam int NUM_BLOCKS       = 256;
  localparam int FAT_BLOCKS       = 8;
  localparam int NAME_CHARS       = 5;
  localparam int DEF_ROOT_ENTRIES = 12;

  localparam int BLK_W  = 8;
  localparam int NAME_W = 40;
  localparam int OP_W   = 3;
  localparam int STAT_W = 3;

  localparam int FREE_START = FAT_BLOCKS + 2;

  typedef logic [BLK_W-1:0]  block_t;
  typedef logic [NAME_W-1:0] name_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam logic [63:0] NAME_MASK64 =
    (NAME_CHARS >= 8) ? '1 : ((64'd1 << (8 * NAME_CHARS)) - 64'd1);
  localparam name_t NAME_MASK = NAME_MASK64[NAME_W-1:0];

  localparam block_t FREE_HEAD_RST =
    (FREE_START < NUM_BLOCKS) ? block_t'(FREE_START) : '0;

  // opcodes
  localparam op_t OP_CREATE = 3'd0;
  localparam op_t OP_REMOVE = 3'd1;
  localparam op_t OP_GET    = 3'd2;
  localparam op_t OP_APPEND = 3'd3;
  localparam op_t OP_DELETE = 3'd4;

  // status codes
  localparam stat_t ST_OK          = 3'd0;
  localparam stat_t ST_NOT_FOUND   = 3'd1;
  localparam stat_t ST_DISK_FULL   = 3'd2;
  localparam stat_t ST_NOT_EMPTY   = 3'd3;
  localparam stat_t ST_DIR_FULL    = 3'd4;
  localparam stat_t ST_NOT_IN_FILE = 3'd5;

  // table read address select
  localparam logic [1:0] FRD_FREE = 2'd0;
  localparam logic [1:0] FRD_CUR  = 2'd1;
  localparam logic [1:0] FRD_BN   = 2'd2;

  // table write select: address <= data
  localparam logic [1:0] FWR_CUR_AB   = 2'd0;
  localparam logic [1:0] FWR_AB_ZERO  = 2'd1;
  localparam logic [1:0] FWR_CUR_LINK = 2'd2;
  localparam logic [1:0] FWR_BN_FREE  = 2'd3;

  // directory write select
  localparam logic [1:0] DWR_CREATE     = 2'd0;
  localparam logic [1:0] DWR_FIRST_AB   = 2'd1;
  localparam logic [1:0] DWR_FIRST_LINK = 2'd2;

  localparam logic CUR_FIRST = 1'b0;
  localparam logic CUR_LINK  = 1'b1;

  localparam logic FREE_LINK = 1'b0;
  localparam logic FREE_BN   = 1'b1;

  localparam logic [1:0] BOUT_ZERO  = 2'd0;
  localparam logic [1:0] BOUT_FIRST = 2'd1;
  localparam logic [1:0] BOUT_AB    = 2'd2;

  typedef struct packed {
    op_t    opcode;
    name_t  file_name;
    block_t block_number;
  } req_t;

  typedef struct packed {
    stat_t  status;
    block_t block_out;
  } rsp_t;

  typedef struct packed {
    logic       busy;
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       dir_rd;
    logic       dir_wr;
    logic [1:0] dir_wr_sel;
    logic       used_set;
    logic       used_clr;
    logic       fat_rd;
    logic [1:0] fat_rd_sel;
    logic       fat_wr;
    logic [1:0] fat_wr_sel;
    logic       cur_ld;
    logic       cur_sel;
    logic       ab_ld;
    logic       free_ld;
    logic       free_sel;
    logic       pend_ld;
    stat_t      pend_status;
    logic [1:0] pend_bout_sel;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic dir_match;
    logic dir_last;
    logic first_zero;
    logic bn_zero;
    logic first_eq_bn;
    logic free_empty;
    logic link_zero;
    logic link_eq_bn;
    logic out_free;
  } sts_t;

  // table contents after reset: a free chain from the first data block
  function automatic block_t fat_reset_link(block_t a);
    int ai;
    ai = int'(a);
    if (ai >= FREE_START && ai + 1 < NUM_BLOCKS) begin
      return block_t'(ai + 1);
    end
    return '0;
  endfunction

endpackage

>>> hdl/fcba_dp.sv
// fcba_dp: datapath of the allocator: directory memory and used bits,
// allocation table memory with valid bits, walk pointers, result registers.
// Depends on fcba_pkg.
module fcba_dp import fcba_pkg::*; #(
  parameter int ROOT_ENTRIES = DEF_ROOT_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  req_t req_data,
  input  logic rsp_stall,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  output rsp_t rsp_data
);

  localparam int IDX_W = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;

  typedef struct packed {
    name_t  name;
    block_t first;
  } dir_word_t;

  req_t                   item;
  logic [IDX_W-1:0]       idx;
  dir_word_t              dir_mem [ROOT_ENTRIES];
  dir_word_t              dir_q;
  dir_word_t              dir_wdata;
  logic [ROOT_ENTRIES-1:0] used;
  logic                   used_q;

  block_t                 fat_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]  fat_valid;
  block_t                 fat_q;
  block_t                 fat_aq;
  logic                   fat_vq;
  block_t                 fat_raddr;
  block_t                 fat_waddr;
  block_t                 fat_wdata;
  block_t                 link;

  block_t                 free_head;
  block_t                 cur;
  block_t                 ab;
  rsp_t                   pend;
  block_t                 pend_bout;
  logic                   name_eq;

  // entries never written still hold their reset link
  assign link = fat_vq ? fat_q : fat_reset_link(fat_aq);

  always_comb begin
    unique case (cmd.fat_rd_sel)
      FRD_FREE: fat_raddr = free_head;
      FRD_CUR:  fat_raddr = cur;
      default:  fat_raddr = item.block_number;
    endcase
  end

  always_comb begin
    unique case (cmd.fat_wr_sel)
      FWR_CUR_AB: begin
        fat_waddr = cur;
        fat_wdata = ab;
      end
      FWR_AB_ZERO: begin
        fat_waddr = ab;
        fat_wdata = '0;
      end
      FWR_CUR_LINK: begin
        fat_waddr = cur;
        fat_wdata = link;
      end
      FWR_BN_FREE: begin
        fat_waddr = item.block_number;
        fat_wdata = free_head;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.dir_wr_sel)
      DWR_CREATE:     dir_wdata = '{name: item.file_name, first: '0};
      DWR_FIRST_AB:   dir_wdata = '{name: dir_q.name, first: ab};
      default:        dir_wdata = '{name: dir_q.name, first: link};
    endcase
  end

  always_comb begin
    unique case (cmd.pend_bout_sel)
      BOUT_FIRST: pend_bout = dir_q.first;
      BOUT_AB:    pend_bout = ab;
      default:    pend_bout = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fat_wr) begin
      fat_mem[fat_waddr] <= fat_wdata;
    end
    if (cmd.fat_rd) begin
      fat_q  <= fat_mem[fat_raddr];
      fat_vq <= fat_valid[fat_raddr];
      fat_aq <= fat_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_valid <= '0;
    end else if (cmd.fat_wr) begin
      fat_valid[fat_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dir_wr) begin
      dir_mem[idx] <= dir_wdata;
    end
    if (cmd.dir_rd) begin
      dir_q  <= dir_mem[idx];
      used_q <= used[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.used_set) begin
      used[idx] <= 1'b1;
    end else if (cmd.used_clr) begin
      used[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req_data;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.cur_ld) begin
      cur <= (cmd.cur_sel == CUR_LINK) ? link : dir_q.first;
    end
    if (cmd.ab_ld) begin
      ab <= free_head;
    end
    if (cmd.pend_ld) begin
      pend <= '{status: cmd.pend_status, block_out: pend_bout};
    end
    if (cmd.out_ld) begin
      rsp_data <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= FREE_HEAD_RST;
    end else if (cmd.free_ld) begin
      free_head <= (cmd.free_sel == FREE_BN) ? item.block_number : link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign name_eq = ((dir_q.name ^ item.file_name) & NAME_MASK) == '0;

  always_comb begin
    sts.op          = item.opcode;
    // create looks for a free slot, everything else for a used name
    sts.dir_match   = (item.opcode == OP_CREATE) ? !used_q : (used_q && name_eq);
    sts.dir_last    = idx == IDX_W'(ROOT_ENTRIES - 1);
    sts.first_zero  = dir_q.first == '0;
    sts.bn_zero     = item.block_number == '0;
    sts.first_eq_bn = dir_q.first == item.block_number;
    sts.free_empty  = free_head == '0;
    sts.link_zero   = link == '0;
    sts.link_eq_bn  = link == item.block_number;
    sts.out_free    = !rsp_valid || !rsp_stall;
  end

endmodule

>>> hdl/fcba_ctl.sv
// fcba_ctl: request sequencer: directory scan, chain walks for append and
// delete, and hand-off of the result beat. Drives the datapath by cmd_t.
// Depends on fcba_pkg.
module fcba_ctl import fcba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_DIR_RD   = 4'd2;
  localparam logic [3:0] S_DIR_CMP  = 4'd3;
  localparam logic [3:0] S_A_LINK   = 4'd4;
  localparam logic [3:0] S_W_RD     = 4'd5;
  localparam logic [3:0] S_W_CHK    = 4'd6;
  localparam logic [3:0] S_A_CLR    = 4'd7;
  localparam logic [3:0] S_D_RD     = 4'd8;
  localparam logic [3:0] S_D_CHK    = 4'd9;
  localparam logic [3:0] S_D_RD_BN  = 4'd10;
  localparam logic [3:0] S_D_UNLINK = 4'd11;
  localparam logic [3:0] S_D_FREE   = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.busy   = 1'b1;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.busy = 1'b0;
        if (req_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.op > OP_DELETE) begin
          cmd.pend_ld     = 1'b1;
          cmd.pend_status = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else if (sts.op == OP_APPEND && sts.free_empty) begin
          // disk full wins over an unknown name
          cmd.pend_ld     = 1'b1;
          cmd.pend_status = ST_DISK_FULL;
          state_next      = S_DONE;
        end else begin
          state_next = S_DIR_RD;
        end
      end
      S_DIR_RD: begin
        cmd.dir_rd = 1'b1;
        state_next = S_DIR_CMP;
      end
      S_DIR_CMP: begin
        priority if (sts.dir_match) begin
          unique case (sts.op)
            OP_CREATE: begin
              cmd.dir_wr      = 1'b1;
              cmd.dir_wr_sel  = DWR_CREATE;
              cmd.used_set    = 1'b1;
              cmd.pend_ld     = 1'b1;
              cmd.pend_status = ST_OK;
              state_next      = S_DONE;
            end
            OP_REMOVE: begin
              cmd.pend_ld = 1'b1;
              if (sts.first_zero) begin
                cmd.used_clr    = 1'b1;
                cmd.pend_status = ST_OK;
              end else begin
                cmd.pend_status = ST_NOT_EMPTY;
              end
              state_next = S_DONE;
            end
            OP_GET: begin
              cmd.pend_ld       = 1'b1;
              cmd.pend_status   = ST_OK;
              cmd.pend_bout_sel = BOUT_FIRST;
              state_next        = S_DONE;
            end
            OP_APPEND: begin
              cmd.ab_ld      = 1'b1;
              cmd.fat_rd     = 1'b1;
              cmd.fat_rd_sel = FRD_FREE;
              state_next     = S_A_LINK;
            end
            OP_DELETE: begin
              priority if (sts.first_zero || sts.bn_zero) begin
                cmd.pend_ld     = 1'b1;
                cmd.pend_status = ST_NOT_IN_FILE;
                state_next      = S_DONE;
              end else if (sts.first_eq_bn) begin
                state_next = S_D_RD_BN;
              end else begin
                cmd.cur_ld  = 1'b1;
                cmd.cur_sel = CUR_FIRST;
                state_next  = S_D_RD;
              end
            end
            default: begin
              cmd.pend_ld     = 1'b1;
              cmd.pend_status = ST_NOT_FOUND;
              state_next      = S_DONE;
            end
          endcase
        end else if (sts.dir_last) begin
          cmd.pend_ld     = 1'b1;
          cmd.pend_status = (sts.op == OP_CREATE) ? ST_DIR_FULL : ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_DIR_RD;
        end
      end
      S_A_LINK: begin
        // pop the free list head
        cmd.free_ld  = 1'b1;
        cmd.free_sel = FREE_LINK;
        if (sts.first_zero) begin
          cmd.dir_wr     = 1'b1;
          cmd.dir_wr_sel = DWR_FIRST_AB;
          state_next     = S_A_CLR;
        end else begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_sel = CUR_FIRST;
          state_next  = S_W_RD;
        end
      end
      S_W_RD: begin
        cmd.fat_rd     = 1'b1;
        cmd.fat_rd_sel = FRD_CUR;
        state_next     = S_W_CHK;
      end
      S_W_CHK: begin
        if (sts.link_zero) begin
          cmd.fat_wr     = 1'b1;
          cmd.fat_wr_sel = FWR_CUR_AB;
          state_next     = S_A_CLR;
        end else begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_sel = CUR_LINK;
          state_next  = S_W_RD;
        end
      end
      S_A_CLR: begin
        cmd.fat_wr        = 1'b1;
        cmd.fat_wr_sel    = FWR_AB_ZERO;
        cmd.pend_ld       = 1'b1;
        cmd.pend_status   = ST_OK;
        cmd.pend_bout_sel = BOUT_AB;
        state_next        = S_DONE;
      end
      S_D_RD: begin
        cmd.fat_rd     = 1'b1;
        cmd.fat_rd_sel = FRD_CUR;
        state_next     = S_D_CHK;
      end
      S_D_CHK: begin
        priority if (sts.link_zero) begin
          cmd.pend_ld     = 1'b1;
          cmd.pend_status = ST_NOT_IN_FILE;
          state_next      = S_DONE;
        end else if (sts.link_eq_bn) begin
          state_next = S_D_RD_BN;
        end else begin
          cmd.cur_ld  = 1'b1;
          cmd.cur_sel = CUR_LINK;
          state_next  = S_D_RD;
        end
      end
      S_D_RD_BN: begin
        cmd.fat_rd     = 1'b1;
        cmd.fat_rd_sel = FRD_BN;
        state_next     = S_D_UNLINK;
      end
      S_D_UNLINK: begin
        // splice out the block: either the file head or the predecessor link
        if (sts.first_eq_bn) begin
          cmd.dir_wr     = 1'b1;
          cmd.dir_wr_sel = DWR_FIRST_LINK;
        end else begin
          cmd.fat_wr     = 1'b1;
          cmd.fat_wr_sel = FWR_CUR_LINK;
        end
        state_next = S_D_FREE;
      end
      S_D_FREE: begin
        cmd.fat_wr      = 1'b1;
        cmd.fat_wr_sel  = FWR_BN_FREE;
        cmd.free_ld     = 1'b1;
        cmd.free_sel    = FREE_BN;
        cmd.pend_ld     = 1'b1;
        cmd.pend_status = ST_OK;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/fat_chain_block_allocator.sv
// fat_chain_block_allocator: top level, joins sequencer and datapath.
// Depends on fcba_pkg, fcba_ctl, fcba_dp.
//
// Usage: one request beat on req (opcode, file_name, block_number) gives one
// response beat on rsp (status, block_out). Both channels use valid/stall;
// a beat moves on an edge with valid high and stall low.
// Requests are handled one at a time. req_stall is low only while the block
// waits for a request. Each directory slot is scanned by one memory read and
// one compare. Create, remove and get answer once the matching slot is found;
// a miss scans every slot. Append then walks the chain to its last link,
// delete walks the chain and splices the block out. Unused opcodes and append
// on a full disk answer without a directory scan. The next request is taken
// the cycle after a response is loaded. The response sits in an output
// register; the next request is accepted while it waits, and that request's
// result waits behind it if rsp_stall stays high. On reset the directory
// empties and the table returns to its initial free chain at once through
// per-block valid bits.
module fat_chain_block_allocator import fcba_pkg::*; #(
  parameter int ROOT_ENTRIES = DEF_ROOT_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  cmd_t cmd;
  sts_t sts;

  fcba_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcba_dp #(
    .ROOT_ENTRIES (ROOT_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  assign req_stall = cmd.busy;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while a request is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> !(rsp_valid && rsp_stall))
    else $error("response register loaded while a stalled beat waits");

  a_rsp_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.out_ld))
    else $error("response valid raised without a load");

  a_error_zero_block: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.block_out == '0)
    else $error("nonzero block returned with an error status");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for fat_chain_block_allocator, holding a model of
// the directory and allocation table. It drives request beats and checks response beats.
// Depends on fcba_pkg and the fat_chain_block_allocator rtl.
module tb_top;
  import fcba_pkg::*;

  localparam int ROOT_N       = DEF_ROOT_ENTRIES;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 2 * ROOT_N + 2 * NUM_BLOCKS + 64;
  localparam int NAME_POOL_N  = 6;
  localparam int EXP_DEPTH    = 16;
  localparam int ROWS_MAX     = 32;

  localparam op_t OP_UNUSED_LO  = 3'd5;
  localparam op_t OP_UNUSED_MID = 3'd6;
  localparam op_t OP_UNUSED_HI  = 3'd7;

  localparam name_t NM_ZERO   = '0;
  localparam name_t NM_ONES   = '1;
  localparam name_t NM_DOLLAR = 40'h2424242424;

  localparam int PH_DIRECTED = 0;
  localparam int PH_MIXED    = 1;
  localparam int PH_FILL     = 2;
  localparam int PH_PRESSURE = 3;
  localparam int PH_DRAIN    = 4;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req_data  = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp_data;

  // allocator model state
  bit     dir_used  [ROOT_N];
  name_t  dir_name  [ROOT_N];
  block_t dir_first [ROOT_N];
  block_t fat       [NUM_BLOCKS];

  // expected beats in order, as a ring
  rsp_t     expected_rsp [EXP_DEPTH];
  int       exp_wr = 0;
  int       exp_rd = 0;
  dir_row_t directed_rows [ROWS_MAX];
  int       row_n = 0;
  name_t    name_pool [NAME_POOL_N];

  int   fail_count    = 0;
  int   cycle_count   = 0;
  int   phase_sel     = PH_DIRECTED;
  int   snk_stall_pct = 0;
  int   src_idle_pct  = 0;
  int   hold_left     = 0;
  bit   hold_done     = 1'b0;
  rsp_t rsp_want;

  fat_chain_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fat_chain_block_allocator test failed");
      $finish;
    end
  end

  // lowest used entry with an equal name wins
  function automatic int find_file(name_t nm);
    int idx;
    int i;
    idx = -1;
    for (i = ROOT_N - 1; i >= 0; i--) begin
      if (dir_used[i] && ((dir_name[i] ^ nm) & NAME_MASK) == '0) idx = i;
    end
    return idx;
  endfunction

  function automatic rsp_t predict_alloc(req_t r);
    rsp_t   o;
    int     e;
    int     i;
    int     n;
    block_t ab;
    block_t cur;
    block_t bn;
    bit     found;
    o.status    = ST_NOT_FOUND;
    o.block_out = '0;
    found       = 1'b0;
    bn          = r.block_number;
    case (r.opcode)
      OP_CREATE: begin
        o.status = ST_DIR_FULL;
        e = -1;
        for (i = ROOT_N - 1; i >= 0; i--) begin
          if (!dir_used[i]) e = i;
        end
        if (e >= 0) begin
          dir_used[e]  = 1'b1;
          dir_name[e]  = r.file_name;
          dir_first[e] = '0;
          o.status     = ST_OK;
        end
      end
      OP_REMOVE: begin
        e = find_file(r.file_name);
        if (e >= 0) begin
          if (dir_first[e] != '0) begin
            o.status = ST_NOT_EMPTY;
          end else begin
            dir_used[e] = 1'b0;
            o.status    = ST_OK;
          end
        end
      end
      OP_GET: begin
        e = find_file(r.file_name);
        if (e >= 0) begin
          o.status    = ST_OK;
          o.block_out = dir_first[e];
        end
      end
      OP_APPEND: begin
        // an empty free list is reported before the name is looked up
        ab = fat[0];
        e  = find_file(r.file_name);
        if (ab == '0) begin
          o.status = ST_DISK_FULL;
        end else if (e >= 0) begin
          fat[0] = fat[ab];
          if (dir_first[e] == '0) begin
            dir_first[e] = ab;
          end else begin
            cur = dir_first[e];
            n   = 0;
            while (n < NUM_BLOCKS && fat[cur] != '0) begin
              cur = fat[cur];
              n++;
            end
            fat[cur] = ab;
          end
          fat[ab]     = '0;
          o.status    = ST_OK;
          o.block_out = ab;
        end
      end
      OP_DELETE: begin
        e = find_file(r.file_name);
        if (e >= 0) begin
          o.status = ST_NOT_IN_FILE;
          cur = dir_first[e];
          if (cur != '0 && bn != '0) begin
            if (cur == bn) begin
              dir_first[e] = fat[bn];
              found = 1'b1;
            end else begin
              n = 0;
              while (!found && n < NUM_BLOCKS && fat[cur] != '0) begin
                if (fat[cur] == bn) begin
                  fat[cur] = fat[bn];
                  found = 1'b1;
                end else begin
                  cur = fat[cur];
                end
                n++;
              end
            end
            if (found) begin
              fat[bn]  = fat[0];
              fat[0]   = bn;
              o.status = ST_OK;
            end
          end
        end
      end
      default: begin
        o.status = ST_NOT_FOUND;
      end
    endcase
    return o;
  endfunction

  task automatic add_row(input op_t op, input name_t nm, input block_t bn, input bit typed,
                         input stat_t st, input block_t bo);
    dir_row_t row;
    row.req.opcode       = op;
    row.req.file_name    = nm;
    row.req.block_number = bn;
    row.typed            = typed;
    row.want.status      = st;
    row.want.block_out   = bo;
    directed_rows[row_n] = row;
    row_n++;
  endtask

  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = predict_alloc(r);
    expected_rsp[exp_wr % EXP_DEPTH] = typed ? want : pred;
    exp_wr++;
  endtask

  // mostly names that are in the directory, with some strangers mixed in
  task automatic gen_req(input int wc, input int wr, input int wg, input int wa, input int wd,
                         output req_t r);
    int     roll;
    int     used_n;
    int     k;
    int     i;
    int     e;
    int     len;
    block_t cur;
    roll = $urandom_range(99);
    r.block_number = block_t'($urandom_range(255));
    if (roll < wc) r.opcode = OP_CREATE;
    else if (roll < wc + wr) r.opcode = OP_REMOVE;
    else if (roll < wc + wr + wg) r.opcode = OP_GET;
    else if (roll < wc + wr + wg + wa) r.opcode = OP_APPEND;
    else if (roll < wc + wr + wg + wa + wd) r.opcode = OP_DELETE;
    else r.opcode = op_t'($urandom_range(int'(OP_UNUSED_HI), int'(OP_UNUSED_LO)));
    used_n = 0;
    for (i = 0; i < ROOT_N; i++) begin
      if (dir_used[i]) used_n++;
    end
    if (r.opcode != OP_CREATE && used_n > 0 && $urandom_range(99) < 88) begin
      k = $urandom_range(used_n - 1);
      for (i = 0; i < ROOT_N; i++) begin
        if (dir_used[i]) begin
          if (k == 0) r.file_name = dir_name[i];
          k--;
        end
      end
    end else if ($urandom_range(99) < 25) begin
      r.file_name = name_t'({$urandom, $urandom});
    end else begin
      r.file_name = name_pool[$urandom_range(NAME_POOL_N - 1)];
    end
    if (r.opcode == OP_DELETE && $urandom_range(99) < 80) begin
      e = find_file(r.file_name);
      if (e >= 0 && dir_first[e] != '0) begin
        len = 0;
        cur = dir_first[e];
        while (cur != '0 && len < NUM_BLOCKS) begin
          len++;
          cur = fat[cur];
        end
        k   = $urandom_range(len - 1);
        cur = dir_first[e];
        repeat (k) cur = fat[cur];
        r.block_number = cur;
      end
    end
  endtask

  task automatic run_phase(input int ph, input int n, input int src_pct, input int snk_pct,
                           input int wc, input int wr, input int wg, input int wa,
                           input int wd);
    req_t r;
    int   k;
    phase_sel     <= ph;
    snk_stall_pct <= snk_pct;
    src_idle_pct   = src_pct;
    for (k = 0; k < n; k++) begin
      gen_req(wc, wr, wg, wa, wd, r);
      send_request(r, 1'b0, '0);
    end
  endtask

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected response beat: status %0d block_out %0d",
               rsp_data.status, rsp_data.block_out);
        fail_count++;
      end else begin
        rsp_want = expected_rsp[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (rsp_data.status !== rsp_want.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 rsp_want.status, rsp_data.status);
          fail_count++;
        end
        if (rsp_data.block_out !== rsp_want.block_out) begin
          $error("block_out mismatch: expected %0d, actual %0d",
                 rsp_want.block_out, rsp_data.block_out);
          fail_count++;
        end
      end
    end
  end

  // receiver stall, with one long hold-off so the block backs up into its request side
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (phase_sel == PH_PRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < snk_stall_pct);
      end
    end
  end

  initial begin
    int i;
    name_pool[0] = NM_ZERO;
    name_pool[1] = NM_ONES;
    name_pool[2] = NM_DOLLAR;
    for (i = 3; i < NAME_POOL_N; i++) name_pool[i] = name_t'({$urandom, $urandom});

    for (i = 0; i < ROOT_N; i++) begin
      dir_used[i]  = 1'b0;
      dir_name[i]  = '0;
      dir_first[i] = '0;
    end
    for (i = 0; i < NUM_BLOCKS; i++) fat[i] = '0;
    fat[0] = FREE_HEAD_RST;
    for (i = FREE_START; i + 1 < NUM_BLOCKS; i++) fat[i] = block_t'(i + 1);

    // empty directory, unknown names, unused opcodes
    add_row(OP_GET,        NM_ZERO,   8'd0,   1'b1, ST_NOT_FOUND, '0);
    add_row(OP_REMOVE,     NM_ZERO,   8'd0,   1'b1, ST_NOT_FOUND, '0);
    add_row(OP_APPEND,     NM_ZERO,   8'd255, 1'b1, ST_NOT_FOUND, '0);
    add_row(OP_DELETE,     NM_ZERO,   8'd255, 1'b1, ST_NOT_FOUND, '0);
    add_row(OP_UNUSED_LO,  NM_ONES,   8'd255, 1'b1, ST_NOT_FOUND, '0);
    add_row(OP_UNUSED_MID, NM_ONES,   8'd0,   1'b1, ST_NOT_FOUND, '0);
    add_row(OP_UNUSED_HI,  NM_DOLLAR, 8'd255, 1'b1, ST_NOT_FOUND, '0);
    // three files, chains built from the head of the free list
    add_row(OP_CREATE,     NM_ZERO,   8'd0,   1'b1, ST_OK, '0);
    add_row(OP_CREATE,     NM_ONES,   8'd255, 1'b1, ST_OK, '0);
    add_row(OP_CREATE,     NM_DOLLAR, 8'd0,   1'b1, ST_OK, '0);
    add_row(OP_GET,        NM_ZERO,   8'd0,   1'b1, ST_OK, '0);
    add_row(OP_APPEND,     NM_ZERO,   8'd0,   1'b1, ST_OK, FREE_HEAD_RST);
    add_row(OP_APPEND,     NM_ZERO,   8'd0,   1'b1, ST_OK, block_t'(FREE_HEAD_RST + 1));
    add_row(OP_APPEND,     NM_ONES,   8'd0,   1'b1, ST_OK, block_t'(FREE_HEAD_RST + 2));
    add_row(OP_APPEND,     NM_ZERO,   8'd0,   1'b0, ST_OK, '0);
    add_row(OP_REMOVE,     NM_ZERO,   8'd0,   1'b1, ST_NOT_EMPTY, '0);
    // block zero and a block owned by another file
    add_row(OP_DELETE,     NM_ZERO,   8'd0,   1'b1, ST_NOT_IN_FILE, '0);
    add_row(OP_DELETE,     NM_ZERO,   block_t'(FREE_HEAD_RST + 2), 1'b1, ST_NOT_IN_FILE, '0);
    // unlink middle, last, then first block
    add_row(OP_DELETE,     NM_ZERO,   block_t'(FREE_HEAD_RST + 1), 1'b0, ST_OK, '0);
    add_row(OP_DELETE,     NM_ZERO,   block_t'(FREE_HEAD_RST + 3), 1'b0, ST_OK, '0);
    add_row(OP_DELETE,     NM_ZERO,   FREE_HEAD_RST,               1'b0, ST_OK, '0);
    add_row(OP_GET,        NM_ZERO,   8'd0,   1'b0, ST_OK, '0);
    add_row(OP_REMOVE,     NM_ZERO,   8'd0,   1'b0, ST_OK, '0);
    // duplicate name lands in the freed lower slot and shadows the older file
    add_row(OP_CREATE,     NM_ONES,   8'd0,   1'b0, ST_OK, '0);
    add_row(OP_DELETE,     NM_ONES,   block_t'(FREE_HEAD_RST + 2), 1'b0, ST_OK, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < row_n; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    //        phase        items src snk  cre rem get app del
    run_phase(PH_MIXED,    60,   0,  0,   25, 10, 15, 30, 15);
    run_phase(PH_FILL,     170,  69, 0,   4,  2,  2,  88, 2);
    run_phase(PH_PRESSURE, 150,  0,  69,  4,  2,  2,  88, 2);
    run_phase(PH_DRAIN,    70,   20, 20,  5,  15, 10, 10, 55);

    req_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && exp_wr == exp_rd) begin
      $display("fat_chain_block_allocator test passed");
    end else begin
      $display("fat_chain_block_allocator test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fcba_pkg.sv
hdl/fcba_dp.sv
hdl/fcba_ctl.sv
hdl/fat_chain_block_allocator.sv
tb/tb_top.sv
